// ----- sv/lks_pkg.sv -----
// Package for the link keepalive supervisor: codes, beat payload types,
// configuration constants. No dependencies.
`default_nettype none

package lks_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_POLL    = 3'd1,
    OP_RX      = 3'd2,
    OP_CONNECT = 3'd3,
    OP_TX_EXT  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_BEGIN       = 3'd0,
    ST_LOGGING_IN  = 3'd1,
    ST_LOGGED_IN   = 3'd2,
    ST_HB_PENDING  = 3'd3,
    ST_HB_ANSWERED = 3'd4
  } status_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MSG_TIMEOUT     = 2'd0,
    REG_CONNECT_TIMEOUT = 2'd1,
    REG_MISS_LIMIT      = 2'd2
  } reg_idx_t;

  localparam logic [15:0] MSG_TIMEOUT_RST     = 16'd10;
  localparam logic [15:0] CONNECT_TIMEOUT_RST = 16'd6;
  localparam logic [7:0]  MISS_LIMIT_RST      = 8'd6;

  localparam logic [7:0]  TYPE_LOGIN_ACK = 8'h01;
  localparam logic [7:0]  TYPE_HB_ACK    = 8'h02;
  localparam logic [15:0] MIN_PACKET_LEN = 16'd8;

  typedef struct packed {
    logic [15:0] msg_timeout;
    logic [15:0] connect_timeout;
    logic [7:0]  miss_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        socket_up;
    logic [15:0] packet_length;
    logic [7:0]  packet_type;
  } item_t;

  typedef struct packed {
    logic        send_login;
    logic        send_heartbeat;
    logic        close_link;
    logic        short_packet;
    logic [2:0]  status;
    logic        link_connected;
    logic [31:0] received_count;
    logic [31:0] sent_count;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/lks_in_if.sv -----
// Input channel of the link keepalive supervisor: valid/ready plus event fields.
// Standalone; no package needed.
`default_nettype none

interface lks_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        socket_up;
  logic [15:0] packet_length;
  logic [7:0]  packet_type;

  modport source (output valid, output op, output socket_up,
                  output packet_length, output packet_type, input ready);
  modport sink   (input valid, input op, input socket_up,
                  input packet_length, input packet_type, output ready);
endinterface

`default_nettype wire

// ----- sv/lks_out_if.sv -----
// Result channel of the link keepalive supervisor: valid/ready plus result fields.
// Standalone; no package needed.
`default_nettype none

interface lks_out_if;
  logic        valid;
  logic        ready;
  logic        send_login;
  logic        send_heartbeat;
  logic        close_link;
  logic        short_packet;
  logic [2:0]  status;
  logic        link_connected;
  logic [31:0] received_count;
  logic [31:0] sent_count;

  modport source (output valid, output send_login, output send_heartbeat,
                  output close_link, output short_packet, output status,
                  output link_connected, output received_count,
                  output sent_count, input ready);
  modport sink   (input valid, input send_login, input send_heartbeat,
                  input close_link, input short_packet, input status,
                  input link_connected, input received_count,
                  input sent_count, output ready);
endinterface

`default_nettype wire

// ----- sv/lks_cfg_regs.sv -----
// Configuration register file: timeouts and miss limit, written by index.
// Depends on lks_pkg.
`default_nettype none

module lks_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lks_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  output lks_pkg::cfg_t                          cfg
);
  import lks_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.msg_timeout     <= MSG_TIMEOUT_RST;
      cfg.connect_timeout <= CONNECT_TIMEOUT_RST;
      cfg.miss_limit      <= MISS_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MSG_TIMEOUT:     cfg.msg_timeout     <= cfg_wr_data;
        REG_CONNECT_TIMEOUT: cfg.connect_timeout <= cfg_wr_data;
        REG_MISS_LIMIT:      cfg.miss_limit      <= cfg_wr_data[7:0];
        default: ; // unmapped index: write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/lks_core.sv -----
// Session state and per-event update: status, silence count, connected flag,
// packet counters. Produces the result for the registered item. Depends on lks_pkg.
`default_nettype none

module lks_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  lks_pkg::item_t       item,
  input  lks_pkg::cfg_t        cfg,
  output lks_pkg::result_t     result
);
  import lks_pkg::*;

  status_t     status, status_next;
  logic [15:0] idle, idle_next;
  logic        connected, connected_next;
  logic [31:0] rx_count, rx_count_next;
  logic [31:0] tx_count, tx_count_next;

  logic        login, hb, close, short_pkt;
  status_t     st_login;
  logic [31:0] miss;
  logic        over_msg, over_conn, half_conn;

  assign over_msg  = idle > cfg.msg_timeout;
  assign over_conn = idle > cfg.connect_timeout;
  assign half_conn = {idle, 1'b0} >= {1'b0, cfg.connect_timeout};

  always_comb begin
    status_next    = status;
    idle_next      = idle;
    connected_next = connected;
    rx_count_next  = rx_count;
    tx_count_next  = tx_count;
    login          = 1'b0;
    hb             = 1'b0;
    close          = 1'b0;
    short_pkt      = 1'b0;
    st_login       = status;
    miss           = tx_count - rx_count;

    unique case (op_t'(item.op))
      OP_TICK: begin
        if (idle != 16'hFFFF) idle_next = idle + 16'd1;
      end
      OP_POLL: begin
        if (connected) begin
          login    = item.socket_up && (status == ST_BEGIN);
          st_login = login ? ST_LOGGING_IN : status;
          // unanswered count includes a login sent in this same poll
          miss     = tx_count - rx_count + {31'd0, login};
          if (st_login == ST_LOGGING_IN && over_msg) begin
            status_next = ST_BEGIN;
            close       = miss >= {24'd0, cfg.miss_limit};
          end else if (st_login == ST_HB_PENDING && over_msg) begin
            status_next = ST_LOGGED_IN;
          end else if (over_conn) begin
            close       = 1'b1;
            status_next = ST_BEGIN;
          end else if ((st_login == ST_LOGGED_IN || st_login == ST_HB_ANSWERED)
                       && half_conn) begin
            hb          = 1'b1;
            status_next = ST_HB_PENDING;
          end else begin
            status_next = st_login;
          end
          // login and heartbeat never fall in one poll
          tx_count_next  = tx_count + {31'd0, login | hb};
          connected_next = ~close;
        end
      end
      OP_RX: begin
        idle_next = 16'd0;
        if (item.packet_length < MIN_PACKET_LEN) begin
          short_pkt = 1'b1;
        end else begin
          rx_count_next = rx_count + 32'd1;
          if (item.packet_type == TYPE_HB_ACK)
            status_next = ST_HB_ANSWERED;
          else if (item.packet_type == TYPE_LOGIN_ACK)
            status_next = ST_LOGGED_IN;
        end
      end
      OP_CONNECT: connected_next = 1'b1;
      OP_TX_EXT:  tx_count_next  = tx_count + 32'd1;
      default: ; // unused op codes leave state alone
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= ST_BEGIN;
      idle      <= 16'd0;
      connected <= 1'b0;
      rx_count  <= 32'd0;
      tx_count  <= 32'd0;
    end else if (fire) begin
      status    <= status_next;
      idle      <= idle_next;
      connected <= connected_next;
      rx_count  <= rx_count_next;
      tx_count  <= tx_count_next;
    end
  end

  always_comb begin
    result.send_login     = login;
    result.send_heartbeat = hb;
    result.close_link     = close;
    result.short_packet   = short_pkt;
    result.status         = status_next;
    result.link_connected = connected_next;
    result.received_count = rx_count_next;
    result.sent_count     = tx_count_next;
  end

endmodule

`default_nettype wire

// ----- sv/link_keepalive_supervisor.sv -----
// Top level of the link keepalive supervisor: input register, session core,
// result register. Depends on lks_pkg, lks_in_if, lks_out_if, lks_cfg_regs, lks_core.
//
// Usage:
//   in_ch  - event beats (op, socket_up, packet_length, packet_type); a beat
//            moves when valid and ready are both high at a rising edge.
//   out_ch - one result beat per event beat, in order: pulses for login,
//            heartbeat, close and short frame, plus status, connected flag
//            and the received and sent counts after that event.
//   cfg_*  - write-only register port; index 0 msg_timeout, 1
//            connect_timeout, 2 miss_limit. Write only while idle.
// Timing: an event beat waits in the input register; the session update and
//   result capture then happen together at the edge where the update stage
//   advances, and the result beat is presented from the result register
//   after that edge. One beat per cycle sustained while out_ch keeps ready
//   high; the session registers update as each beat is applied.
// Reset (rst, synchronous, active high): status begin, counts and silence
//   count zero, link not connected, registers to their defaults, both
//   pipeline stages empty.
// Stall: a held result blocks the update stage; the input register still
//   takes a beat while it is empty, then ready drops until out_ch moves.
`default_nettype none

module link_keepalive_supervisor (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lks_in_if.sink                              in_ch,
  lks_out_if.source                           out_ch,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lks_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import lks_pkg::*;

  cfg_t    cfg;
  item_t   item;        // input register payload
  logic    item_valid;
  result_t result;      // core result for the registered item
  result_t res_q;       // result register payload
  logic    res_valid;
  logic    advance;     // registered item is applied and its result captured

  lks_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  // update stage moves when the result slot is free or being drained
  assign advance     = item_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.op            <= in_ch.op;
      item.socket_up     <= in_ch.socket_up;
      item.packet_length <= in_ch.packet_length;
      item.packet_type   <= in_ch.packet_type;
    end
  end

  lks_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= result;
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.send_login     = res_q.send_login;
  assign out_ch.send_heartbeat = res_q.send_heartbeat;
  assign out_ch.close_link     = res_q.close_link;
  assign out_ch.short_packet   = res_q.short_packet;
  assign out_ch.status         = res_q.status;
  assign out_ch.link_connected = res_q.link_connected;
  assign out_ch.received_count = res_q.received_count;
  assign out_ch.sent_count     = res_q.sent_count;

endmodule

`default_nettype wire
